// ----- sv/bayer_dither_halftone_assert.svh -----
// assertion macros for the bayer dither halftone block
// used by the port checker; no dependencies
`ifndef BAYER_DITHER_HALFTONE_ASSERT_SVH
`define BAYER_DITHER_HALFTONE_ASSERT_SVH

// clocked check, masked while reset is high
`define BDH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// clocked check that also holds through reset
`define BDH_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- sv/bdh_pkg.sv -----
// shared types, constants and functions of the bayer dither halftone block
// no dependencies
`timescale 1ns / 1ps

package bdh_pkg;

   localparam int MAX_ORDER_LOG2 = 3;
   localparam int COORD_BITS     = 12;
   localparam int PIXEL_BITS     = 8;
   localparam int OUT_COORD_BITS = 15;
   localparam int LEVEL_BITS     = 8;
   localparam int ORDER_BITS     = 2;
   localparam int OFFS_BITS      = MAX_ORDER_LOG2;
   localparam int IDX_BITS       = 2 * MAX_ORDER_LOG2;
   localparam int THRESH_BITS    = 2 * MAX_ORDER_LOG2;
   localparam int Q_BITS         = 2 * MAX_ORDER_LOG2 + 1;
   localparam int PROD_BITS      = PIXEL_BITS + Q_BITS;
   localparam int REQ_TDATA_BITS = PIXEL_BITS + 2 * COORD_BITS;
   localparam int RSP_FIELD_BITS = 2 * OUT_COORD_BITS + LEVEL_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [LEVEL_BITS-1:0] LEVEL_WHITE = {LEVEL_BITS{1'b1}};
   localparam logic [LEVEL_BITS-1:0] LEVEL_BLACK = '0;

   // register indexes, taken from the word address bit
   typedef enum logic [0:0] {
      REG_PATTERN_MODE = 1'b0,
      REG_ORDER_LOG2   = 1'b1
   } reg_index_type;

   // one classified pixel waiting for the back end
   typedef struct packed {
      logic [Q_BITS-1:0]     q;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic                  mode;
      logic [ORDER_BITS-1:0] order;
   } work_type;

   // clamp the programmed order into the supported range
   function automatic logic [ORDER_BITS-1:0] eff_order(input logic [ORDER_BITS-1:0] raw);
      logic [ORDER_BITS-1:0] k;
      k = raw;
      if (k == '0)
         k = ORDER_BITS'(1);
      if (k > ORDER_BITS'(MAX_ORDER_LOG2))
         k = ORDER_BITS'(MAX_ORDER_LOG2);
      return k;
   endfunction

   // bayer threshold for offset (r, c) of a 2^k square matrix
   function automatic logic [THRESH_BITS-1:0] bayer_threshold(
      input logic [OFFS_BITS-1:0]  r,
      input logic [OFFS_BITS-1:0]  c,
      input logic [ORDER_BITS-1:0] k
   );
      logic [THRESH_BITS-1:0] val;
      logic [THRESH_BITS-1:0] code;
      val = '0;
      for (int b = 0; b < MAX_ORDER_LOG2; b++) begin
         unique case ({r[b], c[b]})
            2'b00:   code = THRESH_BITS'(0);
            2'b01:   code = THRESH_BITS'(2);
            2'b10:   code = THRESH_BITS'(3);
            default: code = THRESH_BITS'(1);
         endcase
         if (b < int'(k))
            val = val | THRESH_BITS'(code << (2 * (int'(k) - 1 - b)));
      end
      return val;
   endfunction

endpackage

// ----- sv/bdh_queue.sv -----
// two-entry queue of classified pixels between front and back end
// depends on bdh_pkg
`timescale 1ns / 1ps

module bdh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bdh_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop,
   output bdh_pkg::work_type pop_data
);

   localparam int PTR_BITS = $clog2(bdh_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(bdh_pkg::QUEUE_DEPTH + 1);

   bdh_pkg::work_type    entry_ff [bdh_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (count_ff != CNT_BITS'(bdh_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(bdh_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(bdh_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- sv/bdh_front.sv -----
// front end: takes input beats, quantizes the pixel and tags mode and order
// depends on bdh_pkg
`timescale 1ns / 1ps

module bdh_front (
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [bdh_pkg::REQ_TDATA_BITS-1:0]       req_tdata,
   input  logic                                     pattern_mode,
   input  logic [bdh_pkg::ORDER_BITS-1:0]           order_log2,
   output logic                                     push_valid,
   input  logic                                     push_ready,
   output bdh_pkg::work_type                        push_data
);

   logic [bdh_pkg::PIXEL_BITS-1:0] pixel;
   logic [bdh_pkg::COORD_BITS-1:0] row_index;
   logic [bdh_pkg::COORD_BITS-1:0] col_index;
   logic [bdh_pkg::ORDER_BITS-1:0] order;
   logic [bdh_pkg::Q_BITS-1:0]     levels;
   logic [bdh_pkg::PROD_BITS-1:0]  product;

   // unpack the beat
   assign pixel     = req_tdata[bdh_pkg::PIXEL_BITS-1:0];
   assign row_index = req_tdata[bdh_pkg::PIXEL_BITS +: bdh_pkg::COORD_BITS];
   assign col_index = req_tdata[bdh_pkg::PIXEL_BITS + bdh_pkg::COORD_BITS +: bdh_pkg::COORD_BITS];

   // quantize: q = pixel * (n*n + 1) >> 8
   assign order   = bdh_pkg::eff_order(order_log2);
   assign levels  = (bdh_pkg::Q_BITS'(1) << (2 * order)) + bdh_pkg::Q_BITS'(1);
   assign product = bdh_pkg::PROD_BITS'(pixel) * bdh_pkg::PROD_BITS'(levels);

   always_comb begin
      push_data.q     = product[bdh_pkg::PROD_BITS-1:bdh_pkg::PIXEL_BITS];
      push_data.row   = row_index;
      push_data.col   = col_index;
      push_data.mode  = pattern_mode;
      push_data.order = order;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// ----- sv/bdh_back.sv -----
// back end: walks each queued pixel through its results into the output register
// depends on bdh_pkg
`timescale 1ns / 1ps

module bdh_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  bdh_pkg::work_type                  head,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bdh_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast
);

   logic [bdh_pkg::IDX_BITS-1:0]       idx_ff, idx_in;
   logic                               valid_ff, valid_in;
   logic [bdh_pkg::OUT_COORD_BITS-1:0] out_row_ff, out_row_in;
   logic [bdh_pkg::OUT_COORD_BITS-1:0] out_col_ff, out_col_in;
   logic [bdh_pkg::LEVEL_BITS-1:0]     level_ff, level_in;
   logic                               last_ff, last_in;
   logic [bdh_pkg::OFFS_BITS-1:0]      mask;
   logic [bdh_pkg::IDX_BITS-1:0]       last_idx;
   logic [bdh_pkg::OFFS_BITS-1:0]      x_off, y_off;
   logic [bdh_pkg::OFFS_BITS-1:0]      thr_r, thr_c;
   logic [bdh_pkg::THRESH_BITS-1:0]    thresh;
   logic                               load;

   assign mask     = (bdh_pkg::OFFS_BITS'(1) << head.order) - 1'b1;
   assign last_idx = (bdh_pkg::IDX_BITS'(1) << (2 * head.order)) - 1'b1;
   assign x_off    = bdh_pkg::OFFS_BITS'(idx_ff >> head.order);
   assign y_off    = idx_ff[bdh_pkg::OFFS_BITS-1:0] & mask;

   // result for the current head and block offset
   always_comb begin
      if (head.mode) begin
         thr_r      = x_off;
         thr_c      = y_off;
         out_row_in = bdh_pkg::OUT_COORD_BITS'(
                         {{(bdh_pkg::OUT_COORD_BITS-bdh_pkg::COORD_BITS){1'b0}}, head.row}
                         << head.order) | bdh_pkg::OUT_COORD_BITS'(x_off);
         out_col_in = bdh_pkg::OUT_COORD_BITS'(
                         {{(bdh_pkg::OUT_COORD_BITS-bdh_pkg::COORD_BITS){1'b0}}, head.col}
                         << head.order) | bdh_pkg::OUT_COORD_BITS'(y_off);
         last_in    = (idx_ff == last_idx);
      end else begin
         thr_r      = head.row[bdh_pkg::OFFS_BITS-1:0] & mask;
         thr_c      = head.col[bdh_pkg::OFFS_BITS-1:0] & mask;
         out_row_in = bdh_pkg::OUT_COORD_BITS'(head.row);
         out_col_in = bdh_pkg::OUT_COORD_BITS'(head.col);
         last_in    = 1'b1;
      end
      thresh   = bdh_pkg::bayer_threshold(thr_r, thr_c, head.order);
      level_in = (head.q > bdh_pkg::Q_BITS'(thresh)) ? bdh_pkg::LEVEL_WHITE
                                                      : bdh_pkg::LEVEL_BLACK;
   end

   // output register refills from a valid queue head whenever it is empty or being drained
   assign load = head_valid && (!valid_ff || rsp_tready);
   assign pop  = load && last_in;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = last_in ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         level_ff   <= level_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = bdh_pkg::RSP_TDATA_BITS'({level_ff, out_col_ff, out_row_ff});

endmodule

// ----- sv/bayer_dither_halftone.sv -----
// top level of the bayer ordered dither / halftone block with its register port
// depends on bdh_pkg, bdh_front, bdh_queue, bdh_back
//
//  channel  | direction | beat contents
//  req      | in        | pixel, row_index, col_index
//  rsp      | out       | out_row, out_col, level; last on tlast
//  csr      | in/out    | pattern_mode at 0x0, order_log2 at 0x4
//
// ordered mode: one pixel per cycle while rsp is not stalled, one result each
// pattern mode: N*N results per pixel, one per cycle from the back end counter while rsp is not stalled
// a two-entry queue lets the front keep taking pixels while rsp is stalled
// reset: pattern_mode 0, order_log2 1, queue and output register empty
`timescale 1ns / 1ps

module bayer_dither_halftone (
   input  logic                               clock,
   input  logic                               reset,
   // pixel[7:0], row_index[19:8], col_index[31:20]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bdh_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // out_row[14:0], out_col[29:15], level[37:30], zero[39:38]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bdh_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bdh_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bdh_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bdh_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   logic                           pattern_mode_ff, pattern_mode_in;
   logic [bdh_pkg::ORDER_BITS-1:0] order_log2_ff, order_log2_in;
   bdh_pkg::reg_index_type         reg_sel;
   logic                           csr_write;
   logic                           push_valid, push_ready;
   bdh_pkg::work_type              push_data;
   logic                           head_valid, pop;
   bdh_pkg::work_type              head;

   // register port
   assign csr_pready = 1'b1;
   assign reg_sel    = bdh_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      pattern_mode_in = pattern_mode_ff;
      order_log2_in   = order_log2_ff;
      if (csr_write) begin
         unique case (reg_sel)
            bdh_pkg::REG_PATTERN_MODE: pattern_mode_in = csr_pwdata[0];
            bdh_pkg::REG_ORDER_LOG2:   order_log2_in   = csr_pwdata[bdh_pkg::ORDER_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         bdh_pkg::REG_PATTERN_MODE: csr_prdata = bdh_pkg::CSR_DATA_BITS'(pattern_mode_ff);
         bdh_pkg::REG_ORDER_LOG2:   csr_prdata = bdh_pkg::CSR_DATA_BITS'(order_log2_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_mode_ff <= 1'b0;
         order_log2_ff   <= bdh_pkg::ORDER_BITS'(1);
      end else begin
         pattern_mode_ff <= pattern_mode_in;
         order_log2_ff   <= order_log2_in;
      end
   end

   // front end
   bdh_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .pattern_mode (pattern_mode_ff),
      .order_log2   (order_log2_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   // queue between the two halves
   bdh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop        (pop),
      .pop_data   (head)
   );

   // back end
   bdh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/bdh_checker.sv -----
// port-level checks of the bayer dither halftone block, bound to the top level
// depends on bdh_pkg and bayer_dither_halftone_assert.svh
`timescale 1ns / 1ps
`include "bayer_dither_halftone_assert.svh"

module bdh_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bdh_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast,
   input logic                               csr_pready
);

   // a stalled result beat keeps its contents
   `BDH_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp beat changed while stalled")

   // a block burst runs without gaps until its last beat
   `BDH_ASSERT(a_burst_gapless, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid, "gap inside a pattern block")

   // output register is empty right after reset
   `BDH_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")

   // register port never waits
   `BDH_ASSERT_ALWAYS(a_pready_high, csr_pready, "csr_pready dropped")

endmodule

bind bayer_dither_halftone bdh_checker u_bdh_checker (.*);

// ----- sim/tb_top.sv -----
// self-checking bench for the bayer dither halftone block: random bursts of pixels,
// per-beat comparison against an in-bench halftone predictor across all register settings
// depends on bdh_pkg and bayer_dither_halftone
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT = 2000;

   // one pixel beat, pixel in the low bits as on req_tdata
   typedef struct packed {
      logic [bdh_pkg::COORD_BITS-1:0] col;
      logic [bdh_pkg::COORD_BITS-1:0] row;
      logic [bdh_pkg::PIXEL_BITS-1:0] pixel;
   } pixel_beat_type;

   // one halftone output pixel
   typedef struct {
      logic [bdh_pkg::OUT_COORD_BITS-1:0] row;
      logic [bdh_pkg::OUT_COORD_BITS-1:0] col;
      logic [bdh_pkg::LEVEL_BITS-1:0]     level;
      logic                               last;
   } halftone_px_type;

   logic                               clock;
   logic                               reset       = 1'b1;
   logic                               req_tvalid  = 1'b0;
   logic                               req_tready;
   // pixel[7:0], row_index[19:8], col_index[31:20]
   logic [bdh_pkg::REQ_TDATA_BITS-1:0] req_tdata   = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready  = 1'b0;
   // out_row[14:0], out_col[29:15], level[37:30], zero[39:38]
   logic [bdh_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tlast;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [bdh_pkg::CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [bdh_pkg::CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [bdh_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                               csr_pready;

   // pixels waiting to be sent and halftone pixels still owed by the block
   pixel_beat_type  pixel_q[$];
   halftone_px_type halftone_q[$];

   // bench copy of the registers
   logic                           cfg_pattern = 1'b0;
   logic [bdh_pkg::ORDER_BITS-1:0] cfg_order   = bdh_pkg::ORDER_BITS'(1);

   int error_count = 0;
   int burst_left  = 0;
   int gap_left    = 0;
   int idle_cycles = 0;
   int pat_age     = 0;
   logic [15:0]     ready_pat = 16'hFFFF;
   halftone_px_type want_px;
   halftone_px_type got_px;

   bayer_dither_halftone u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // threshold rank of offset (r, c) in a 2^k bayer matrix; offset msb has weight 1
   function automatic int bayer_rank(input int r, input int c, input int k);
      int rank;
      int rb;
      int cb;
      rank = 0;
      for (int b = 0; b < k; b++) begin
         rb = (r >> b) & 1;
         cb = (c >> b) & 1;
         rank += (2 * (rb ^ cb) + rb) << (2 * (k - 1 - b));
      end
      return rank;
   endfunction

   // work out the halftone pixels that one input pixel produces
   task automatic predict_halftone(input pixel_beat_type beat);
      int k;
      int n;
      int q;
      halftone_px_type px;
      k = (cfg_order == '0) ? 1 : int'(cfg_order);
      if (k > bdh_pkg::MAX_ORDER_LOG2)
         k = bdh_pkg::MAX_ORDER_LOG2;
      n = 1 << k;
      q = (int'(beat.pixel) * (n * n + 1)) >> 8;
      if (!cfg_pattern) begin
         px.row   = bdh_pkg::OUT_COORD_BITS'(beat.row);
         px.col   = bdh_pkg::OUT_COORD_BITS'(beat.col);
         px.level = (q > bayer_rank(int'(beat.row) & (n - 1), int'(beat.col) & (n - 1), k))
                    ? bdh_pkg::LEVEL_WHITE : bdh_pkg::LEVEL_BLACK;
         px.last  = 1'b1;
         halftone_q.push_back(px);
      end else begin
         // block expansion, row-major over the n by n offsets
         for (int x = 0; x < n; x++) begin
            for (int y = 0; y < n; y++) begin
               px.row   = bdh_pkg::OUT_COORD_BITS'(int'(beat.row) * n + x);
               px.col   = bdh_pkg::OUT_COORD_BITS'(int'(beat.col) * n + y);
               px.level = (q > bayer_rank(x, y, k)) ? bdh_pkg::LEVEL_WHITE
                                                    : bdh_pkg::LEVEL_BLACK;
               px.last  = (x == n - 1) && (y == n - 1);
               halftone_q.push_back(px);
            end
         end
      end
   endtask

   // pixel driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_halftone(pixel_q[0]);
            void'(pixel_q.pop_front());
            if (burst_left > 0)
               burst_left--;
         end
         // hold the beat while it is stalled
         if (!(req_tvalid && !req_tready)) begin
            if (burst_left == 0 && gap_left == 0) begin
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               burst_left = $urandom_range(1, 16);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pixel_q[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with its own rotating stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_px.row   = rsp_tdata[14:0];
            got_px.col   = rsp_tdata[29:15];
            got_px.level = rsp_tdata[37:30];
            got_px.last  = rsp_tlast;
            if (halftone_q.size() == 0) begin
               $display("%0t: unexpected beat row=%0d col=%0d level=%0d last=%0b", $time,
                        got_px.row, got_px.col, got_px.level, got_px.last);
               error_count++;
            end else begin
               want_px = halftone_q.pop_front();
               if (got_px.row !== want_px.row || got_px.col !== want_px.col ||
                   got_px.level !== want_px.level || got_px.last !== want_px.last) begin
                  $display("%0t: mismatch expected row=%0d col=%0d level=%0d last=%0b",
                           $time, want_px.row, want_px.col, want_px.level, want_px.last);
                  $display("%0t:          actual   row=%0d col=%0d level=%0d last=%0b",
                           $time, got_px.row, got_px.col, got_px.level, got_px.last);
                  error_count++;
               end
            end
         end
         // pick a new stall pattern now and then, sometimes none at all
         if (pat_age == 0) begin
            ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            pat_age   = $urandom_range(16, 96);
         end
         pat_age--;
         ready_pat = {ready_pat[14:0], ready_pat[15]};
         rsp_tready <= ready_pat[0];
      end
   end

   // watchdog on cycles with no beat moving anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // register write: setup cycle then access cycle
   task automatic csr_write(input bdh_pkg::reg_index_type idx,
                            input logic [bdh_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         bdh_pkg::REG_PATTERN_MODE: cfg_pattern = value[0];
         bdh_pkg::REG_ORDER_LOG2:   cfg_order   = value[bdh_pkg::ORDER_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic add_pixel(input int pix, input int row, input int col);
      pixel_beat_type beat;
      beat.pixel = bdh_pkg::PIXEL_BITS'(pix);
      beat.row   = bdh_pkg::COORD_BITS'(row);
      beat.col   = bdh_pkg::COORD_BITS'(col);
      pixel_q.push_back(beat);
   endtask

   // random pixels with extra weight on the field extremes
   task automatic add_random(input int count);
      int pix;
      int row;
      int col;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 7))
            0:       pix = 0;
            1:       pix = 255;
            default: pix = $urandom_range(0, 255);
         endcase
         case ($urandom_range(0, 7))
            0:       row = 0;
            1:       row = 4095;
            default: row = $urandom_range(0, 4095);
         endcase
         case ($urandom_range(0, 7))
            0:       col = 0;
            1:       col = 4095;
            default: col = $urandom_range(0, 4095);
         endcase
         add_pixel(pix, row, col);
      end
   endtask

   // let every queued pixel go through and every owed result come back
   task automatic wait_drain();
      while (pixel_q.size() != 0 || req_tvalid || halftone_q.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: ordered, 2x2, field extremes and all four offsets
      add_pixel(0, 0, 0);
      add_pixel(255, 4095, 4095);
      add_pixel(128, 0, 1);
      add_pixel(64, 1, 0);
      add_pixel(1, 1, 1);
      add_pixel(254, 2730, 1365);
      add_random(15);
      wait_drain();

      // order zero acts as 2x2; upper data bits ignored
      csr_write(bdh_pkg::REG_ORDER_LOG2, 32'hFFFF_FFFC);
      @(negedge clock);
      add_pixel(191, 3, 2);
      add_pixel(192, 2, 3);
      add_random(10);
      wait_drain();

      csr_write(bdh_pkg::REG_ORDER_LOG2, 32'd2);
      @(negedge clock);
      add_random(15);
      wait_drain();

      // largest matrix in ordered mode
      csr_write(bdh_pkg::REG_ORDER_LOG2, 32'd3);
      @(negedge clock);
      add_pixel(255, 4095, 4095);
      add_pixel(0, 7, 7);
      add_pixel(227, 5, 6);
      add_random(15);
      wait_drain();

      // block expansion at 8x8, including the largest output coordinates
      csr_write(bdh_pkg::REG_PATTERN_MODE, 32'hFFFF_FFFF);
      @(negedge clock);
      add_pixel(255, 4095, 4095);
      add_pixel(0, 0, 0);
      add_random(4);
      wait_drain();

      csr_write(bdh_pkg::REG_ORDER_LOG2, 32'd1);
      @(negedge clock);
      add_random(20);
      wait_drain();

      csr_write(bdh_pkg::REG_ORDER_LOG2, 32'd2);
      @(negedge clock);
      add_random(12);
      wait_drain();

      csr_write(bdh_pkg::REG_ORDER_LOG2, 32'd0);
      @(negedge clock);
      add_pixel(128, 4095, 0);
      add_random(8);
      wait_drain();

      // back to ordered mode, bit 0 clear with other bits set
      csr_write(bdh_pkg::REG_PATTERN_MODE, 32'h0000_0002);
      csr_write(bdh_pkg::REG_ORDER_LOG2, 32'd3);
      @(negedge clock);
      add_random(20);
      wait_drain();

      // trailing pause to catch stray beats
      repeat (8) @(posedge clock);
      if (halftone_q.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, halftone_q.size());
         error_count++;
      end
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bdh_pkg.sv
sv/bdh_queue.sv
sv/bdh_front.sv
sv/bdh_back.sv
sv/bayer_dither_halftone.sv
sv/bdh_checker.sv
sim/tb_top.sv
